@@ sv/mpcf_pkg.sv @@
`timescale 1ns / 1ps

package mpcf_pkg;

    // Fixed field widths of the item payloads.
    localparam int unsigned FIELD_PKT_W = 32;
    localparam int unsigned IN_PORTS    = 4;
    localparam int unsigned OUT_PORTS   = 4;
    // Cells look this many slots ahead; a grant never exceeds the four output ports.
    localparam int unsigned LOOK        = 5;
    localparam int unsigned LOOK_W      = 3;
    // Counts are held wide enough for a depth of 256 plus the look-ahead.
    localparam int unsigned CNT_W       = 10;

    typedef struct packed {
        logic [2:0]             enq_count;
        logic [2:0]             deq_request;
        logic [FIELD_PKT_W-1:0] enq_pkt_0;
        logic [FIELD_PKT_W-1:0] enq_pkt_1;
        logic [FIELD_PKT_W-1:0] enq_pkt_2;
        logic [FIELD_PKT_W-1:0] enq_pkt_3;
    } t_in_item;

    typedef struct packed {
        logic [2:0]             deq_granted;
        logic [FIELD_PKT_W-1:0] out_pkt_0;
        logic [FIELD_PKT_W-1:0] out_pkt_1;
        logic [FIELD_PKT_W-1:0] out_pkt_2;
        logic [FIELD_PKT_W-1:0] out_pkt_3;
        logic [4:0]             occupancy;
        logic [2:0]             dropped;
    } t_out_item;

    // Shift/fill command broadcast from the control to every cell.
    typedef struct packed {
        logic             load;
        logic [LOOK_W-1:0] grant;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] take;
    } t_cell_ctrl;

    function automatic logic [CNT_W-1:0] min_cnt(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

@@ sv/mpcf_cell.sv @@
`timescale 1ns / 1ps

module mpcf_cell #(
    parameter int unsigned IDX       = 0,
    parameter int unsigned PKT_WIDTH = 32
) (
    input  logic                                          i_clk,
    input  mpcf_pkg::t_cell_ctrl                          i_ctrl,
    input  logic [mpcf_pkg::LOOK-1:0][PKT_WIDTH-1:0]      i_fwd,
    input  logic [mpcf_pkg::IN_PORTS-1:0][PKT_WIDTH-1:0]  i_pkts,
    output logic [PKT_WIDTH-1:0]                          o_slot
);

    logic [PKT_WIDTH-1:0]         r_slot;
    logic [PKT_WIDTH-1:0]         n_slot;
    logic [mpcf_pkg::CNT_W-1:0]   w_src;
    logic [mpcf_pkg::CNT_W-1:0]   w_new_pos;

    // The slot's new content sits at position IDX + grant of the old queue
    // with the offered packets appended after the last valid entry.
    always_comb begin
        w_src     = mpcf_pkg::CNT_W'(IDX) + mpcf_pkg::CNT_W'(i_ctrl.grant);
        w_new_pos = w_src - i_ctrl.fill;
        n_slot    = r_slot;
        if (w_src < i_ctrl.fill) begin
            n_slot = i_fwd[i_ctrl.grant];
        end else if (w_new_pos < i_ctrl.take) begin
            n_slot = i_pkts[w_new_pos[1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

@@ sv/mpcf_ctrl.sv @@
`timescale 1ns / 1ps

module mpcf_ctrl #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned MAX_ENQ     = 4,
    parameter int unsigned MAX_DEQ     = 4,
    parameter int unsigned PKT_WIDTH   = 32
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_enqueue_first,
    input  logic                                           i_in_valid,
    output logic                                           o_in_stall,
    input  mpcf_pkg::t_in_item                             i_in_item,
    output logic                                           o_out_valid,
    input  logic                                           i_out_stall,
    output mpcf_pkg::t_out_item                            o_out_item,
    input  logic [mpcf_pkg::OUT_PORTS-1:0][PKT_WIDTH-1:0]  i_heads,
    output logic [mpcf_pkg::IN_PORTS-1:0][PKT_WIDTH-1:0]   o_pkts,
    output mpcf_pkg::t_cell_ctrl                           o_ctrl
);

    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned ENQ_LIM = (MAX_ENQ < mpcf_pkg::IN_PORTS) ?
                                      MAX_ENQ : mpcf_pkg::IN_PORTS;
    localparam int unsigned DEQ_LIM = (MAX_DEQ < mpcf_pkg::OUT_PORTS) ?
                                      MAX_DEQ : mpcf_pkg::OUT_PORTS;
    localparam int unsigned CW = mpcf_pkg::CNT_W;

    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic                r_out_valid;
    logic                n_out_valid;
    mpcf_pkg::t_out_item r_out;
    mpcf_pkg::t_out_item n_out;

    logic                w_accept;
    logic [CW-1:0]       w_fill;
    logic [CW-1:0]       w_n_enq;
    logic [CW-1:0]       w_req;
    logic [CW-1:0]       w_room;
    logic [CW-1:0]       w_take;
    logic [CW-1:0]       w_grant;
    logic [CW-1:0]       w_occ;
    logic [CW-1:0]       w_off;
    logic [mpcf_pkg::OUT_PORTS-1:0][mpcf_pkg::FIELD_PKT_W-1:0] w_out_pkt;

    assign o_pkts[0] = PKT_WIDTH'(i_in_item.enq_pkt_0);
    assign o_pkts[1] = PKT_WIDTH'(i_in_item.enq_pkt_1);
    assign o_pkts[2] = PKT_WIDTH'(i_in_item.enq_pkt_2);
    assign o_pkts[3] = PKT_WIDTH'(i_in_item.enq_pkt_3);

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_fill  = CW'(r_fill);
        w_n_enq = mpcf_pkg::min_cnt(CW'(i_in_item.enq_count), CW'(ENQ_LIM));
        w_req   = mpcf_pkg::min_cnt(CW'(i_in_item.deq_request), CW'(DEQ_LIM));
        if (i_enqueue_first) begin
            w_room  = CW'(QUEUE_DEPTH) - w_fill;
            w_take  = mpcf_pkg::min_cnt(w_n_enq, w_room);
            w_grant = mpcf_pkg::min_cnt(w_req, w_fill + w_take);
        end else begin
            w_grant = mpcf_pkg::min_cnt(w_req, w_fill);
            w_room  = CW'(QUEUE_DEPTH) - w_fill + w_grant;
            w_take  = mpcf_pkg::min_cnt(w_n_enq, w_room);
        end
        w_occ = w_fill + w_take - w_grant;

        // A granted port beyond the old contents reads a packet that joined
        // in the same step.
        for (int k = 0; k < mpcf_pkg::OUT_PORTS; k++) begin
            w_off        = CW'(k) - w_fill;
            w_out_pkt[k] = '0;
            if (CW'(k) < w_grant) begin
                if (CW'(k) < w_fill) begin
                    w_out_pkt[k] = mpcf_pkg::FIELD_PKT_W'(i_heads[k]);
                end else begin
                    w_out_pkt[k] = mpcf_pkg::FIELD_PKT_W'(o_pkts[w_off[1:0]]);
                end
            end
        end

        n_out.deq_granted = w_grant[2:0];
        n_out.out_pkt_0   = w_out_pkt[0];
        n_out.out_pkt_1   = w_out_pkt[1];
        n_out.out_pkt_2   = w_out_pkt[2];
        n_out.out_pkt_3   = w_out_pkt[3];
        n_out.occupancy   = w_occ[4:0];
        n_out.dropped     = 3'(w_n_enq - w_take);

        n_fill      = w_accept ? FILL_W'(w_occ) : r_fill;
        n_out_valid = w_accept ? 1'b1 : (r_out_valid && i_out_stall);

        o_ctrl.load  = w_accept;
        o_ctrl.grant = w_grant[mpcf_pkg::LOOK_W-1:0];
        o_ctrl.fill  = w_fill;
        o_ctrl.take  = w_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ sv/multi_port_compacting_fifo_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                    Payload
// input     i_in_valid / o_in_stall      i_in_item  (mpcf_pkg::t_in_item)
// output    o_out_valid / i_out_stall    o_out_item (mpcf_pkg::t_out_item)
// config    i_cfg_we                     i_cfg_wdata (enqueue_first)
//
// Each item is handled at its accepting edge: the slot cells shift and fill
// in parallel and the result lands in the output register, so one item per
// clock is sustained if not stalled. A new item is taken while a result waits
// unless the output is stalled with a result already held. Reset empties the
// queue and clears enqueue_first; the slot cells themselves are not cleared.

module multi_port_compacting_fifo_top #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned MAX_ENQ     = 4,
    parameter int unsigned MAX_DEQ     = 4,
    parameter int unsigned PKT_WIDTH   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mpcf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mpcf_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);

    localparam int unsigned CHAIN = QUEUE_DEPTH + mpcf_pkg::LOOK - 1;

    logic                                          r_enqueue_first;
    mpcf_pkg::t_cell_ctrl                          w_ctrl;
    logic [mpcf_pkg::IN_PORTS-1:0][PKT_WIDTH-1:0]  w_pkts;
    logic [CHAIN-1:0][PKT_WIDTH-1:0]               w_chain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enqueue_first <= 1'b0;
        end else if (i_cfg_we) begin
            r_enqueue_first <= i_cfg_wdata;
        end
    end

    mpcf_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_ENQ     (MAX_ENQ),
        .MAX_DEQ     (MAX_DEQ),
        .PKT_WIDTH   (PKT_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_enqueue_first (r_enqueue_first),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_item       (i_in_item),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_item      (o_out_item),
        .i_heads         (w_chain[mpcf_pkg::OUT_PORTS-1:0]),
        .o_pkts          (w_pkts),
        .o_ctrl          (w_ctrl)
    );

    // Slots past the end of the queue read as zero; no grant reaches them
    // while they would matter.
    assign w_chain[CHAIN-1:QUEUE_DEPTH] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        mpcf_cell #(
            .IDX       (i),
            .PKT_WIDTH (PKT_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_fwd  (w_chain[i +: mpcf_pkg::LOOK]),
            .i_pkts (w_pkts),
            .o_slot (w_chain[i])
        );
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned QDEPTH     = 16;
    localparam int unsigned PORT_LIMIT = 4;
    localparam int          PHASE_LEN  = 283;
    localparam int          CYCLE_LIMIT = 200000;

    // Step-accurate model of the queue with the results it still owes.
    class fifo_step_checker;
        bit                  enq_first;
        logic [31:0]         held_pkts[$];
        mpcf_pkg::t_out_item pending_results[$];
        int                  failures;

        function new();
            enq_first = 1'b0;
            failures  = 0;
        endfunction

        // Appends up to n offered packets and returns how many found no room.
        function int admit(mpcf_pkg::t_in_item it, int n);
            logic [31:0] offer [4];
            int lost;
            lost = 0;
            offer[0] = it.enq_pkt_0;
            offer[1] = it.enq_pkt_1;
            offer[2] = it.enq_pkt_2;
            offer[3] = it.enq_pkt_3;
            for (int i = 0; i < n; i++) begin
                if (held_pkts.size() < QDEPTH) held_pkts = {held_pkts, offer[i]};
                else lost++;
            end
            return lost;
        endfunction

        function void note_input(mpcf_pkg::t_in_item it);
            logic [31:0] leaving [4];
            mpcf_pkg::t_out_item res;
            int offered, wanted, grant;
            res = '0;
            leaving = '{default: '0};
            offered = (it.enq_count > PORT_LIMIT) ? PORT_LIMIT : it.enq_count;
            wanted  = (it.deq_request > PORT_LIMIT) ? PORT_LIMIT : it.deq_request;
            if (enq_first) res.dropped = 3'(admit(it, offered));
            grant = (wanted < held_pkts.size()) ? wanted : held_pkts.size();
            for (int i = 0; i < grant; i++) leaving[i] = held_pkts.pop_front();
            if (!enq_first) res.dropped = 3'(admit(it, offered));
            res.deq_granted = 3'(grant);
            res.out_pkt_0   = leaving[0];
            res.out_pkt_1   = leaving[1];
            res.out_pkt_2   = leaving[2];
            res.out_pkt_3   = leaving[3];
            res.occupancy   = 5'(held_pkts.size());
            pending_results = {pending_results, res};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s expected %0h got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(mpcf_pkg::t_out_item got);
            mpcf_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result arrived with no item outstanding");
                failures++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("deq_granted", 32'(want.deq_granted), 32'(got.deq_granted));
            compare_field("out_pkt_0", want.out_pkt_0, got.out_pkt_0);
            compare_field("out_pkt_1", want.out_pkt_1, got.out_pkt_1);
            compare_field("out_pkt_2", want.out_pkt_2, got.out_pkt_2);
            compare_field("out_pkt_3", want.out_pkt_3, got.out_pkt_3);
            compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    mpcf_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    mpcf_pkg::t_out_item o_out_item;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_wdata = 1'b0;

    fifo_step_checker checker_h = new();
    int send_idle = 0;
    int recv_idle = 0;
    int cycle_count = 0;

    multi_port_compacting_fifo_top #(
        .QUEUE_DEPTH(QDEPTH),
        .MAX_ENQ    (4),
        .MAX_DEQ    (4),
        .PKT_WIDTH  (32)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) checker_h.check_result(o_out_item);
    end

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return $urandom;
    endfunction

    // Filling stretches push the queue toward full, the others drain it.
    function automatic mpcf_pkg::t_in_item rand_item(bit filling);
        mpcf_pkg::t_in_item it;
        it.enq_count   = 3'(($urandom_range(99) < 10) ? $urandom_range(7, 5) :
                            (filling ? $urandom_range(4, 2) : $urandom_range(2, 0)));
        it.deq_request = 3'(($urandom_range(99) < 10) ? $urandom_range(7, 5) :
                            (filling ? $urandom_range(2, 0) : $urandom_range(4, 2)));
        it.enq_pkt_0   = rand_word();
        it.enq_pkt_1   = rand_word();
        it.enq_pkt_2   = rand_word();
        it.enq_pkt_3   = rand_word();
        return it;
    endfunction

    task automatic send_item(mpcf_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_in_item  <= rand_item(1'($urandom_range(1)));
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        checker_h.note_input(it);
    endtask

    task automatic send_counts(int enq, int deq);
        mpcf_pkg::t_in_item it;
        it = rand_item(1'b0);
        it.enq_count   = 3'(enq);
        it.deq_request = 3'(deq);
        send_item(it);
    endtask

    // Holds the sender off until every owed result has been taken.
    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (checker_h.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_mode(bit enq_first);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= enq_first;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        checker_h.enq_first = enq_first;
    endtask

    task automatic run_phase(int n, int s_idle, int r_idle);
        bit filling;
        int stretch;
        send_idle = s_idle;
        recv_idle = r_idle;
        filling = 1'b1;
        stretch = $urandom_range(40, 10);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) wait_quiet();
            if (stretch == 0) begin
                filling = !filling;
                stretch = $urandom_range(40, 10);
            end
            stretch--;
            send_item(rand_item(filling));
        end
    endtask

    initial begin
        mpcf_pkg::t_in_item edge_item;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Dequeue before enqueue: empty requests, saturated counts, overflow.
        set_mode(1'b0);
        send_counts(0, 0);
        send_counts(0, 4);
        edge_item = '0;
        edge_item.enq_count = 3'd4;
        edge_item.enq_pkt_0 = '1;
        edge_item.enq_pkt_1 = '0;
        edge_item.enq_pkt_2 = 32'h5555_5555;
        edge_item.enq_pkt_3 = 32'hAAAA_AAAA;
        send_item(edge_item);
        send_counts(7, 7);
        repeat (4) send_counts(4, 0);
        send_counts(3, 1);
        repeat (4) send_counts(0, 6);

        // Enqueue first: new packets may leave in the same step, full queue drops.
        set_mode(1'b1);
        send_counts(4, 4);
        send_counts(5, 7);
        repeat (4) send_counts(4, 0);
        send_counts(4, 4);
        repeat (3) send_counts(0, 7);

        for (int p = 0; p < 6; p++) begin
            set_mode(p[0]);
            unique case (p / 2)
                0: run_phase(PHASE_LEN, 26, 73);
                1: run_phase(PHASE_LEN, 73, 26);
                default: run_phase(PHASE_LEN, 0, 0);
            endcase
        end

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (checker_h.failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/mpcf_pkg.sv
sv/mpcf_cell.sv
sv/mpcf_ctrl.sv
sv/multi_port_compacting_fifo_top.sv
verif/testbench.sv
